>>> sv/i2cbm_pkg.sv
// ----------------------------------------------------------------------------
// i2cbm_pkg
// Shared codes, types and reset constants for the I2C bit master.
// ----------------------------------------------------------------------------
`default_nettype none

package i2cbm_pkg;

  // Raw mode codes as they arrive on the input stream
  localparam logic [2:0] MODE_NONE      = 3'd0;
  localparam logic [2:0] MODE_START     = 3'd1;
  localparam logic [2:0] MODE_STOP      = 3'd2;
  localparam logic [2:0] MODE_SEND      = 3'd3;
  localparam logic [2:0] MODE_WAIT_ACK  = 3'd4;
  localparam logic [2:0] MODE_READ_ACK  = 3'd5;
  localparam logic [2:0] MODE_READ_NACK = 3'd6;

  // Decoded command codes handed to the engine
  localparam logic [2:0] CMD_NONE      = 3'd0;
  localparam logic [2:0] CMD_START     = 3'd1;
  localparam logic [2:0] CMD_STOP      = 3'd2;
  localparam logic [2:0] CMD_SEND      = 3'd3;
  localparam logic [2:0] CMD_WAIT_ACK  = 3'd4;
  localparam logic [2:0] CMD_READ_ACK  = 3'd5;
  localparam logic [2:0] CMD_READ_NACK = 3'd6;

  // Engine phases
  localparam logic [4:0] PH_IDLE    = 5'd0;
  localparam logic [4:0] PH_ST1     = 5'd1;
  localparam logic [4:0] PH_ST2     = 5'd2;
  localparam logic [4:0] PH_ST3     = 5'd3;
  localparam logic [4:0] PH_SP1     = 5'd4;
  localparam logic [4:0] PH_SP2     = 5'd5;
  localparam logic [4:0] PH_SP3     = 5'd6;
  localparam logic [4:0] PH_SP4     = 5'd7;
  localparam logic [4:0] PH_TX_HI   = 5'd8;
  localparam logic [4:0] PH_TX_LO   = 5'd9;
  localparam logic [4:0] PH_TX_NEXT = 5'd10;
  localparam logic [4:0] PH_WA1     = 5'd11;
  localparam logic [4:0] PH_WA_POLL = 5'd12;
  localparam logic [4:0] PH_RD_HI   = 5'd13;
  localparam logic [4:0] PH_RD_NEXT = 5'd14;
  localparam logic [4:0] PH_AK1     = 5'd15;
  localparam logic [4:0] PH_AK2     = 5'd16;

  // Configuration register indexes and reset values
  localparam logic       REG_HALF_PERIOD  = 1'b0;
  localparam logic       REG_ACK_TIMEOUT  = 1'b1;
  localparam logic [15:0] HALF_PERIOD_RST = 16'd20;
  localparam logic [7:0]  ACK_TIMEOUT_RST = 8'd250;

  // One tick after classification
  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] tx_byte;
    logic       sda_in;
  } q_item_t;

  // Head of the tick queue as seen by the engine
  typedef struct packed {
    logic    valid;
    q_item_t item;
  } q_head_t;

  // Live configuration
  typedef struct packed {
    logic [15:0] half_period_ticks;
    logic [7:0]  ack_timeout_ticks;
  } cfg_t;

endpackage

`default_nettype wire

>>> sv/i2cbm_front.sv
// ----------------------------------------------------------------------------
// i2cbm_front
// Accepts tick requests, decodes the mode field and queues them (2 deep).
// ----------------------------------------------------------------------------
`default_nettype none

module i2cbm_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  input  wire logic [15:0]       s_tdata,   // [7:0] tx_byte, [8] sda_in, rest zero
  input  wire logic [2:0]        s_tuser,   // [2:0] mode
  output i2cbm_pkg::q_head_t     head,
  input  wire logic              pop
);
  import i2cbm_pkg::*;

  q_item_t    entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       take;
  q_item_t    decoded;

  // Map raw mode to a command; meaningless codes become no-ops
  always_comb begin
    decoded.tx_byte = s_tdata[7:0];
    decoded.sda_in  = s_tdata[8];
    case (s_tuser)
      MODE_START:     decoded.cmd = CMD_START;
      MODE_STOP:      decoded.cmd = CMD_STOP;
      MODE_SEND:      decoded.cmd = CMD_SEND;
      MODE_WAIT_ACK:  decoded.cmd = CMD_WAIT_ACK;
      MODE_READ_ACK:  decoded.cmd = CMD_READ_ACK;
      MODE_READ_NACK: decoded.cmd = CMD_READ_NACK;
      default:        decoded.cmd = CMD_NONE;
    endcase
  end

  assign s_tready   = (count != 2'd2);
  assign push       = s_tvalid && s_tready;
  assign take       = pop && (count != 2'd0);
  assign head.valid = (count != 2'd0);
  assign head.item  = entries[rd_ptr];

  // Store the incoming request
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= decoded;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (take) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, take};
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (count == 2'd2) |-> !push)
    else $error("tick queue written while full");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3)
    else $error("tick queue count out of range");

endmodule

`default_nettype wire

>>> sv/i2cbm_engine.sv
// ----------------------------------------------------------------------------
// i2cbm_engine
// Bus phase sequencer: one queued tick per step, result held in an output
// register until taken.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cbm_engine (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire i2cbm_pkg::cfg_t   cfg,
  input  wire i2cbm_pkg::q_head_t head,
  output logic                   pop,
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  output logic [15:0]            m_tdata    // [0] scl_out, [1] sda_out, [2] busy_res,
                                            // [3] done_res, [11:4] rx_byte,
                                            // [12] ack_fail, rest zero
);
  import i2cbm_pkg::*;

  logic [4:0]  phase, phase_next;
  logic [3:0]  bit_count, bit_count_next;
  logic [7:0]  shift_reg, shift_reg_next;
  logic [15:0] delay_count, delay_count_next;
  logic [7:0]  wait_count, wait_count_next;
  logic        scl, scl_next;
  logic        sda, sda_next;
  logic        fail_flag, fail_flag_next;
  logic [7:0]  rx_hold, rx_hold_next;
  logic        ack_nack, ack_nack_next;
  logic        done_next;
  logic        step;
  logic [15:0] hold_val;
  logic [3:0]  bit_inc;
  q_item_t     it;

  assign it   = head.item;
  assign step = head.valid && (!m_tvalid || m_tready);
  assign pop  = step;

  // Reload for a held level; zero half period counts as one tick
  assign hold_val = (cfg.half_period_ticks == 16'd0) ? 16'd0
                                                     : cfg.half_period_ticks - 16'd1;
  assign bit_inc  = bit_count + 4'd1;

  // Compute the state after one tick
  always_comb begin
    phase_next       = phase;
    bit_count_next   = bit_count;
    shift_reg_next   = shift_reg;
    delay_count_next = delay_count;
    wait_count_next  = wait_count;
    scl_next         = scl;
    sda_next         = sda;
    fail_flag_next   = fail_flag;
    rx_hold_next     = rx_hold;
    ack_nack_next    = ack_nack;
    done_next        = 1'b0;
    if (phase == PH_IDLE) begin
      case (it.cmd)
        CMD_START: begin
          sda_next = 1'b1;
          delay_count_next = hold_val;
          phase_next = PH_ST1;
        end
        CMD_STOP: begin
          scl_next = 1'b0;
          delay_count_next = hold_val;
          phase_next = PH_SP1;
        end
        CMD_SEND: begin
          scl_next = 1'b0;
          bit_count_next = 4'd0;
          sda_next = it.tx_byte[7];
          shift_reg_next = {it.tx_byte[6:0], 1'b0};
          delay_count_next = hold_val;
          phase_next = PH_TX_HI;
        end
        CMD_WAIT_ACK: begin
          sda_next = 1'b1;
          fail_flag_next = 1'b0;
          wait_count_next = 8'd0;
          delay_count_next = hold_val;
          phase_next = PH_WA1;
        end
        CMD_READ_ACK, CMD_READ_NACK: begin
          ack_nack_next = (it.cmd == CMD_READ_NACK);
          sda_next = 1'b1;
          scl_next = 1'b0;
          bit_count_next = 4'd0;
          shift_reg_next = 8'd0;
          delay_count_next = hold_val;
          phase_next = PH_RD_HI;
        end
        default: begin
        end
      endcase
    end else if (delay_count != 16'd0) begin
      delay_count_next = delay_count - 16'd1;
    end else begin
      case (phase)
        PH_ST1: begin
          scl_next = 1'b1;
          delay_count_next = hold_val;
          phase_next = PH_ST2;
        end
        PH_ST2: begin
          sda_next = 1'b0;
          delay_count_next = hold_val;
          phase_next = PH_ST3;
        end
        PH_ST3: begin
          scl_next = 1'b0;
          done_next = 1'b1;
          phase_next = PH_IDLE;
        end
        PH_SP1: begin
          sda_next = 1'b0;
          delay_count_next = hold_val;
          phase_next = PH_SP2;
        end
        PH_SP2: begin
          scl_next = 1'b1;
          delay_count_next = hold_val;
          phase_next = PH_SP3;
        end
        PH_SP3: begin
          sda_next = 1'b1;
          delay_count_next = hold_val;
          phase_next = PH_SP4;
        end
        PH_SP4: begin
          done_next = 1'b1;
          phase_next = PH_IDLE;
        end
        PH_TX_HI: begin
          scl_next = 1'b1;
          delay_count_next = hold_val;
          phase_next = PH_TX_LO;
        end
        PH_TX_LO: begin
          scl_next = 1'b0;
          delay_count_next = hold_val;
          phase_next = PH_TX_NEXT;
        end
        PH_TX_NEXT: begin
          bit_count_next = bit_inc;
          if (bit_inc >= 4'd8) begin
            done_next = 1'b1;
            phase_next = PH_IDLE;
          end else begin
            sda_next = shift_reg[7];
            shift_reg_next = {shift_reg[6:0], 1'b0};
            delay_count_next = hold_val;
            phase_next = PH_TX_HI;
          end
        end
        PH_WA1: begin
          scl_next = 1'b1;
          delay_count_next = hold_val;
          phase_next = PH_WA_POLL;
        end
        PH_WA_POLL: begin
          if (!it.sda_in) begin
            scl_next = 1'b0;
            fail_flag_next = 1'b0;
            done_next = 1'b1;
            phase_next = PH_IDLE;
          end else if (wait_count >= cfg.ack_timeout_ticks) begin
            fail_flag_next = 1'b1;
            scl_next = 1'b0;
            delay_count_next = hold_val;
            phase_next = PH_SP1;
          end else begin
            wait_count_next = wait_count + 8'd1;
          end
        end
        PH_RD_HI: begin
          scl_next = 1'b1;
          shift_reg_next = {shift_reg[6:0], it.sda_in};
          phase_next = PH_RD_NEXT;
        end
        PH_RD_NEXT: begin
          bit_count_next = bit_inc;
          scl_next = 1'b0;
          delay_count_next = hold_val;
          if (bit_inc >= 4'd8) begin
            rx_hold_next = shift_reg;
            sda_next = ack_nack;
            phase_next = PH_AK1;
          end else begin
            phase_next = PH_RD_HI;
          end
        end
        PH_AK1: begin
          scl_next = 1'b1;
          delay_count_next = hold_val;
          phase_next = PH_AK2;
        end
        PH_AK2: begin
          scl_next = 1'b0;
          done_next = 1'b1;
          phase_next = PH_IDLE;
        end
        default: begin
          phase_next = PH_IDLE;
          delay_count_next = 16'd0;
        end
      endcase
    end
  end

  // Commit the tick and capture its result
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      bit_count   <= 4'd0;
      shift_reg   <= 8'd0;
      delay_count <= 16'd0;
      wait_count  <= 8'd0;
      scl         <= 1'b1;
      sda         <= 1'b1;
      fail_flag   <= 1'b0;
      rx_hold     <= 8'd0;
      ack_nack    <= 1'b0;
      m_tvalid    <= 1'b0;
    end else begin
      if (step) begin
        phase       <= phase_next;
        bit_count   <= bit_count_next;
        shift_reg   <= shift_reg_next;
        delay_count <= delay_count_next;
        wait_count  <= wait_count_next;
        scl         <= scl_next;
        sda         <= sda_next;
        fail_flag   <= fail_flag_next;
        rx_hold     <= rx_hold_next;
        ack_nack    <= ack_nack_next;
        m_tvalid    <= 1'b1;
      end else if (m_tready) begin
        m_tvalid    <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (step) begin
      m_tdata <= {3'd0, fail_flag_next, rx_hold_next, done_next,
                  (phase_next != PH_IDLE), sda_next, scl_next};
    end
  end

  a_idle_no_delay: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_IDLE) |-> (delay_count == 16'd0))
    else $error("delay count left running while idle");

  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[3]) |-> !m_tdata[2])
    else $error("done reported with busy still set");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    !step |=> (phase == $past(phase)) && (delay_count == $past(delay_count)))
    else $error("engine state moved without a tick");

endmodule

`default_nettype wire

>>> sv/i2c_bit_master.sv
// ----------------------------------------------------------------------------
// i2c_bit_master
// Open-drain I2C master stepped once per tick request: START, STOP, byte send,
// ACK wait with timeout, byte read with ACK or NACK.
// ----------------------------------------------------------------------------
// A result is registered on m_tdata after its tick has passed through the tick queue and the engine.
// Throughput: one tick per cycle while the result output is not stalled; the engine steps once per queued tick.
// A 2-deep tick queue buffers incoming ticks while the output is stalled.
// Reset (rst, synchronous): engine idle, both lines released, counters and
// received byte cleared, half period 20 and ACK timeout 250.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_bit_master (
  input  wire logic        clk,
  input  wire logic        rst,
  // tick stream in
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [15:0] s_tdata,   // [7:0] tx_byte, [8] sda_in, rest zero
  input  wire logic [2:0]  s_tuser,   // [2:0] mode
  // result stream out
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,   // [0] scl_out, [1] sda_out, [2] busy_res,
                                      // [3] done_res, [11:4] rx_byte,
                                      // [12] ack_fail, rest zero
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import i2cbm_pkg::*;

  cfg_t    cfg;
  q_head_t head;
  logic    pop;
  logic    wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.half_period_ticks <= HALF_PERIOD_RST;
      cfg.ack_timeout_ticks <= ACK_TIMEOUT_RST;
    end else if (wr_en) begin
      if (paddr[2] == REG_HALF_PERIOD) begin
        cfg.half_period_ticks <= pwdata[15:0];
      end else begin
        cfg.ack_timeout_ticks <= pwdata[7:0];
      end
    end
  end

  // Register reads
  always_comb begin
    if (paddr[2] == REG_ACK_TIMEOUT) begin
      prdata = {24'd0, cfg.ack_timeout_ticks};
    end else begin
      prdata = {16'd0, cfg.half_period_ticks};
    end
  end

  i2cbm_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .head     (head),
    .pop      (pop)
  );

  i2cbm_engine u_engine (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .head     (head),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

`default_nettype wire

>>> bench/i2cbm_checker.sv
// ----------------------------------------------------------------------------
// i2cbm_checker
// Watches the tick, result and register channels of the I2C bit master.
// Keeps its own copy of the engine state and configuration, computes the
// bus state that each accepted tick request must produce, and compares every
// accepted result field by field with the oldest computed state.
// ----------------------------------------------------------------------------
module i2cbm_checker
  import i2cbm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [15:0] s_tdata,   // [7:0] tx_byte, [8] sda_in, rest zero
  input  logic [2:0]  s_tuser,   // [2:0] mode
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [15:0] m_tdata,   // [0] scl, [1] sda, [2] busy, [3] done,
                                 // [11:4] rx_byte, [12] ack_fail, rest zero
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          mismatches,
  output int          results_pending,
  output logic        engine_busy,
  output int          cmds_started
);
  timeunit 1ns;
  timeprecision 1ps;

  // Bus state after one tick, laid out as on m_tdata
  typedef struct packed {
    logic [2:0] pad;
    logic       ack_fail;
    logic [7:0] rx_byte;
    logic       done;
    logic       busy;
    logic       sda;
    logic       scl;
  } bus_state_t;

  localparam int PRINT_CAP = 100;

  // Configuration copy
  logic [15:0] half_ticks;
  logic [7:0]  ack_limit;

  // Engine copy
  logic [4:0]  eng_phase;
  logic [3:0]  bit_idx;
  logic [7:0]  shifter;
  logic [15:0] hold_left;
  logic [7:0]  poll_count;
  logic        scl_drv;
  logic        sda_drv;
  logic        ack_failed;
  logic        give_nack;
  logic [7:0]  last_rx;
  logic        cmd_done;

  bus_state_t  pending_states[$];
  int          result_idx;
  int          cmd_total;

  // Set a new level and hold it for the configured number of ticks
  function automatic void start_level(input logic [4:0] nxt);
    hold_left = (half_ticks == 16'd0) ? 16'd0 : half_ticks - 16'd1;
    eng_phase = nxt;
  endfunction

  function automatic void end_command();
    cmd_done  = 1'b1;
    eng_phase = PH_IDLE;
    hold_left = 16'd0;
  endfunction

  // Put the next data bit on SDA, MSB first
  function automatic void drive_msb();
    sda_drv = shifter[7];
    shifter = {shifter[6:0], 1'b0};
  endfunction

  // Advance the engine by one tick and return the resulting bus state
  task automatic step_engine(input logic [2:0] mode, input logic [7:0] tx,
                             input logic sda_in, output bus_state_t res,
                             output logic started);
    cmd_done = 1'b0;
    started  = 1'b0;
    if (eng_phase == PH_IDLE) begin
      started = 1'b1;
      case (mode)
        MODE_START: begin
          sda_drv = 1'b1;
          start_level(PH_ST1);
        end
        MODE_STOP: begin
          scl_drv = 1'b0;
          start_level(PH_SP1);
        end
        MODE_SEND: begin
          scl_drv = 1'b0;
          shifter = tx;
          bit_idx = 4'd0;
          drive_msb();
          start_level(PH_TX_HI);
        end
        MODE_WAIT_ACK: begin
          sda_drv    = 1'b1;
          ack_failed = 1'b0;
          poll_count = 8'd0;
          start_level(PH_WA1);
        end
        MODE_READ_ACK, MODE_READ_NACK: begin
          give_nack = (mode == MODE_READ_NACK);
          sda_drv   = 1'b1;
          scl_drv   = 1'b0;
          bit_idx   = 4'd0;
          shifter   = 8'd0;
          start_level(PH_RD_HI);
        end
        default: started = 1'b0;
      endcase
    end else if (hold_left != 16'd0) begin
      hold_left = hold_left - 16'd1;
    end else begin
      case (eng_phase)
        PH_ST1: begin scl_drv = 1'b1; start_level(PH_ST2); end
        PH_ST2: begin sda_drv = 1'b0; start_level(PH_ST3); end
        PH_ST3: begin scl_drv = 1'b0; end_command(); end
        PH_SP1: begin sda_drv = 1'b0; start_level(PH_SP2); end
        PH_SP2: begin scl_drv = 1'b1; start_level(PH_SP3); end
        PH_SP3: begin sda_drv = 1'b1; start_level(PH_SP4); end
        PH_SP4: end_command();
        PH_TX_HI: begin scl_drv = 1'b1; start_level(PH_TX_LO); end
        PH_TX_LO: begin scl_drv = 1'b0; start_level(PH_TX_NEXT); end
        PH_TX_NEXT: begin
          bit_idx = bit_idx + 4'd1;
          if (bit_idx >= 4'd8) begin
            end_command();
          end else begin
            drive_msb();
            start_level(PH_TX_HI);
          end
        end
        PH_WA1: begin scl_drv = 1'b1; start_level(PH_WA_POLL); end
        // Poll SDA while SCL is high; give up into a STOP past the limit
        PH_WA_POLL: begin
          if (!sda_in) begin
            scl_drv    = 1'b0;
            ack_failed = 1'b0;
            end_command();
          end else if (poll_count >= ack_limit) begin
            ack_failed = 1'b1;
            scl_drv    = 1'b0;
            start_level(PH_SP1);
          end else begin
            poll_count = poll_count + 8'd1;
          end
        end
        // Sample on the SCL rise, keep SCL high for that tick only
        PH_RD_HI: begin
          scl_drv   = 1'b1;
          shifter   = {shifter[6:0], sda_in};
          hold_left = 16'd0;
          eng_phase = PH_RD_NEXT;
        end
        PH_RD_NEXT: begin
          bit_idx = bit_idx + 4'd1;
          scl_drv = 1'b0;
          if (bit_idx >= 4'd8) begin
            last_rx = shifter;
            sda_drv = give_nack;
            start_level(PH_AK1);
          end else begin
            start_level(PH_RD_HI);
          end
        end
        PH_AK1: begin scl_drv = 1'b1; start_level(PH_AK2); end
        PH_AK2: begin scl_drv = 1'b0; end_command(); end
        default: begin
          eng_phase = PH_IDLE;
          hold_left = 16'd0;
        end
      endcase
    end
    res.pad      = 3'd0;
    res.ack_fail = ack_failed;
    res.rx_byte  = last_rx;
    res.done     = cmd_done;
    res.busy     = (eng_phase != PH_IDLE);
    res.sda      = sda_drv;
    res.scl      = scl_drv;
  endtask

  task automatic flag_mismatch(input string what, input int unsigned want,
                               input int unsigned got);
    if (mismatches < PRINT_CAP)
      $display("%0t: result %0d %s expected 'h%0h got 'h%0h",
               $time, result_idx, what, want, got);
    mismatches++;
  endtask

  // Track all three channels on each clock edge
  always @(posedge clk) begin : track
    bus_state_t want;
    bus_state_t got;
    bus_state_t nxt;
    logic       started;
    if (rst) begin
      half_ticks = HALF_PERIOD_RST;
      ack_limit  = ACK_TIMEOUT_RST;
      eng_phase  = PH_IDLE;
      bit_idx    = 4'd0;
      shifter    = 8'd0;
      hold_left  = 16'd0;
      poll_count = 8'd0;
      scl_drv    = 1'b1;
      sda_drv    = 1'b1;
      ack_failed = 1'b0;
      give_nack  = 1'b0;
      last_rx    = 8'd0;
      result_idx = 0;
      cmd_total  = 0;
      pending_states.delete();
    end else begin
      // Check an accepted result against the oldest computed state
      if (m_tvalid && m_tready) begin
        got = bus_state_t'(m_tdata);
        if (pending_states.size() == 0) begin
          flag_mismatch("result with no tick", 0, m_tdata);
        end else begin
          want = pending_states.pop_front();
          if (got.scl !== want.scl) flag_mismatch("scl_out", want.scl, got.scl);
          if (got.sda !== want.sda) flag_mismatch("sda_out", want.sda, got.sda);
          if (got.busy !== want.busy) flag_mismatch("busy_res", want.busy, got.busy);
          if (got.done !== want.done) flag_mismatch("done_res", want.done, got.done);
          if (got.rx_byte !== want.rx_byte)
            flag_mismatch("rx_byte", want.rx_byte, got.rx_byte);
          if (got.ack_fail !== want.ack_fail)
            flag_mismatch("ack_fail", want.ack_fail, got.ack_fail);
          if (got.pad !== want.pad) flag_mismatch("padding", want.pad, got.pad);
        end
        result_idx++;
      end
      // Step the engine copy on an accepted tick request
      if (s_tvalid && s_tready) begin
        step_engine(s_tuser, s_tdata[7:0], s_tdata[8], nxt, started);
        pending_states.push_back(nxt);
        if (started) cmd_total++;
      end
      // Follow register writes
      if (psel && penable && pwrite && pready) begin
        case (paddr[2])
          REG_HALF_PERIOD: half_ticks = pwdata[15:0];
          REG_ACK_TIMEOUT: ack_limit  = pwdata[7:0];
          default: ;
        endcase
      end
    end
    results_pending <= pending_states.size();
    engine_busy     <= (eng_phase != PH_IDLE);
    cmds_started    <= cmd_total;
  end

endmodule

>>> bench/tb_i2c_bit_master.sv
// ----------------------------------------------------------------------------
// tb_i2c_bit_master
// Drives tick requests and register writes into the I2C bit master and lets
// the checker compare every result. A directed part walks through each
// command, ACK and timeout paths, ignored modes and the timing extremes; a
// random part then runs many commands under varied timing, SDA patterns and
// backpressure, ending with the first ticks of a START at the longest half
// period.
// ----------------------------------------------------------------------------
module tb_i2c_bit_master;
  import i2cbm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] MODE_UNUSED = 3'd7;
  localparam int         CYCLE_LIMIT = 200_000;
  localparam int         PHASE_CMDS  = 3;
  localparam int         STEADY_CMDS = 8;
  localparam int         LONG_TICKS  = 16;

  typedef enum logic [1:0] {SDA_NOISE, SDA_HELD_HIGH, SDA_HELD_LOW} sda_drive_t;

  logic        clk;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata  = '0;  // [7:0] tx_byte, [8] sda_in, rest zero
  logic [2:0]  s_tuser  = '0;  // [2:0] mode
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;        // [0] scl, [1] sda, [2] busy, [3] done,
                               // [11:4] rx_byte, [12] ack_fail, rest zero
  logic        psel     = 1'b0;
  logic        penable  = 1'b0;
  logic        pwrite   = 1'b0;
  logic [2:0]  paddr    = '0;
  logic [31:0] pwdata   = '0;
  logic [31:0] prdata;
  logic        pready;

  int          mismatches;
  int          results_pending;
  logic        engine_busy;
  int          cmds_started;
  int          cycle_count = 0;
  logic        steady      = 1'b0;
  sda_drive_t  sda_policy  = SDA_NOISE;

  i2c_bit_master uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  i2cbm_checker chk (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready),
    .mismatches(mismatches), .results_pending(results_pending),
    .engine_busy(engine_busy), .cmds_started(cmds_started)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Stall the result side at random unless in a steady stretch
  always @(posedge clk) begin
    m_tready <= steady || ($urandom_range(99) >= 13);
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic logic sda_pick();
    case (sda_policy)
      SDA_HELD_HIGH: return 1'b1;
      SDA_HELD_LOW:  return 1'b0;
      default:       return 1'($urandom);
    endcase
  endfunction

  // Offer one tick request, with an occasional gap first; return on accept
  task automatic send_tick(input logic [2:0] mode, input logic [7:0] tx,
                           input logic sda);
    if (!steady && $urandom_range(99) < 13) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= mode;
    s_tdata  <= {7'd0, sda, tx};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Run empty ticks until the engine is idle and every result is back
  task automatic settle();
    s_tvalid <= 1'b0;
    @(negedge clk);
    if (engine_busy) begin
      @(posedge clk);
      do send_tick($urandom_range(1) ? MODE_NONE : MODE_UNUSED, 8'($urandom),
                   sda_pick());
      while (engine_busy);
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    wait (results_pending == 0);
    @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_timing(input logic [15:0] half, input logic [7:0] limit);
    write_reg(REG_HALF_PERIOD, {16'($urandom), half});
    write_reg(REG_ACK_TIMEOUT, {24'($urandom), limit});
  endtask

  // Issue one command, try two more while it runs, then let it finish
  task automatic run_cmd(input logic [2:0] mode, input logic [7:0] tx,
                         input sda_drive_t policy);
    sda_policy = policy;
    send_tick(mode, tx, sda_pick());
    if (mode != MODE_NONE && mode != MODE_UNUSED)
      repeat (2) send_tick(3'($urandom_range(1, 6)), 8'($urandom), sda_pick());
    settle();
  endtask

  initial begin
    int          goal;
    int          stretch;
    int          roll;
    logic [15:0] half;
    logic [7:0]  limit;

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: short commands at reset timing
    run_cmd(MODE_START,     8'h00, SDA_NOISE);
    run_cmd(MODE_WAIT_ACK,  8'h00, SDA_HELD_LOW);
    run_cmd(MODE_UNUSED,    8'h3C, SDA_NOISE);
    run_cmd(MODE_NONE,      8'hC3, SDA_NOISE);
    run_cmd(MODE_STOP,      8'h00, SDA_NOISE);

    // Directed: zero half period and zero ACK timeout
    set_timing(16'd0, 8'd0);
    run_cmd(MODE_START,     8'h00, SDA_NOISE);
    run_cmd(MODE_WAIT_ACK,  8'h00, SDA_HELD_HIGH);
    run_cmd(MODE_WAIT_ACK,  8'h00, SDA_HELD_LOW);
    run_cmd(MODE_SEND,      8'h5A, SDA_NOISE);
    run_cmd(MODE_READ_NACK, 8'h00, SDA_NOISE);
    run_cmd(MODE_READ_ACK,  8'hFF, SDA_HELD_LOW);
    run_cmd(MODE_STOP,      8'h00, SDA_NOISE);

    // Random: command streams under changing timing and SDA patterns
    goal    = cmds_started;
    stretch = 0;
    for (int ph = 0; ph < 12; ph++) begin
      half  = (ph == 0) ? 16'd1 : 16'($urandom_range(0, 4));
      limit = (ph % 4 == 0) ? 8'd255 :
              (ph % 4 == 1) ? 8'($urandom_range(0, 1)) : 8'($urandom_range(2, 40));
      set_timing(half, limit);
      steady = (ph == 5);
      goal   = goal + (steady ? STEADY_CMDS : PHASE_CMDS);
      while (cmds_started < goal) begin
        if (stretch == 0) begin
          roll = $urandom_range(99);
          if (roll < 50)      sda_policy = SDA_NOISE;
          else if (roll < 80) sda_policy = SDA_HELD_HIGH;
          else                sda_policy = SDA_HELD_LOW;
          stretch = $urandom_range(16, 400);
        end
        stretch--;
        send_tick(3'($urandom_range(0, 7)), 8'($urandom), sda_pick());
      end
      settle();
    end
    steady = 1'b0;

    // Longest half period: start a command and follow its first ticks
    set_timing(16'hFFFF, 8'd255);
    sda_policy = SDA_NOISE;
    send_tick(MODE_START, 8'h00, sda_pick());
    repeat (LONG_TICKS) send_tick(MODE_NONE, 8'($urandom), sda_pick());
    s_tvalid <= 1'b0;
    @(negedge clk);
    wait (results_pending == 0);

    repeat (4) @(posedge clk);
    if (mismatches == 0 && results_pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

>>> filelist.f
sv/i2cbm_pkg.sv
sv/i2cbm_front.sv
sv/i2cbm_engine.sv
sv/i2c_bit_master.sv
bench/i2cbm_checker.sv
bench/tb_i2c_bit_master.sv
